### rtl/dual_flow_sensor_odometry_top_macros.svh
// Assertion macros shared by the odometry RTL.
`ifndef DUAL_FLOW_SENSOR_ODOMETRY_TOP_MACROS_SVH
`define DUAL_FLOW_SENSOR_ODOMETRY_TOP_MACROS_SVH
`ifndef ASSERT_OFF
`define DFSO_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error("dfso check failed");
`define DFSO_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) else $error("dfso check failed");
`else
`define DFSO_ASSERT(lbl, clk, rst, prop)
`define DFSO_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

### rtl/dfso_pkg.sv
`default_nettype none
package dfso_pkg;
   localparam logic [23:0] MPC_RESET = 24'd16777;
   localparam logic [23:0] IB_RESET  = 24'd284939;
   localparam logic [23:0] FO_RESET  = 24'd4719;

   localparam logic signed [33:0] HALF_PI_Q30 = 34'sd1686629713;
   localparam logic [30:0] GAIN_Q30 = 31'd652032874;
   localparam logic [19:0] TWO_PI_Q16 = 20'd411775;
   localparam logic signed [20:0] PI_Q16 = 21'sd205887;
   // Reciprocal of two pi in Q16, scaled by 2^42 and rounded down.
   localparam logic [23:0] RECIP_Q42 = 24'd10680703;

   typedef enum logic [1:0] {
      CSR_MPC = 2'd0,
      CSR_IB  = 2'd1,
      CSR_FO  = 2'd2,
      CSR_NONE = 2'd3
   } csr_idx_type;

   typedef enum logic [3:0] {
      OP_RDX, OP_RDY, OP_LDX, OP_LDY, OP_DTH, OP_FHI, OP_FLO, OP_QE, OP_QD, OP_GX, OP_GY
   } op_type;

   typedef enum logic [2:0] {
      S_IDLE, S_MUL, S_CAP, S_ROT, S_WAIT, S_ACC
   } state_type;

   typedef struct packed {
      logic busy;
      logic done;
   } unit_stat_type;

   function automatic logic [30:0] atan_q30(input logic [4:0] i);
      logic [30:0] v;
      case (i)
         5'd0:  v = 31'd843314857;
         5'd1:  v = 31'd497837829;
         5'd2:  v = 31'd263043836;
         5'd3:  v = 31'd133525158;
         5'd4:  v = 31'd67021686;
         5'd5:  v = 31'd33543515;
         5'd6:  v = 31'd16775850;
         5'd7:  v = 31'd8388437;
         5'd8:  v = 31'd4194282;
         5'd9:  v = 31'd2097149;
         5'd10: v = 31'd1048575;
         5'd11: v = 31'd524287;
         5'd12: v = 31'd262143;
         5'd13: v = 31'd131071;
         5'd14: v = 31'd65535;
         5'd15: v = 31'd32767;
         5'd16: v = 31'd16383;
         5'd17: v = 31'd8191;
         5'd18: v = 31'd4095;
         5'd19: v = 31'd2047;
         5'd20: v = 31'd1023;
         5'd21: v = 31'd511;
         5'd22: v = 31'd255;
         5'd23: v = 31'd127;
         5'd24: v = 31'd63;
         5'd25: v = 31'd31;
         5'd26: v = 31'd15;
         5'd27: v = 31'd8;
         5'd28: v = 31'd4;
         5'd29: v = 31'd2;
         5'd30: v = 31'd1;
         default: v = 31'd0;
      endcase
      return v;
   endfunction

   // Clamp to the signed 32-bit range.
   function automatic logic signed [31:0] sat32(input logic signed [51:0] v);
      logic signed [31:0] r;
      if (v > 52'sd2147483647) begin
         r = 32'sh7fffffff;
      end else if (v < -52'sd2147483648) begin
         r = 32'sh80000000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction
endpackage
`default_nettype wire

### rtl/dfso_mul.sv
`default_nettype none
// Shared signed multiplier with a registered product.
module dfso_mul (
   input  wire logic               clock,
   input  wire logic               en,
   input  wire logic signed [35:0] a,
   input  wire logic signed [35:0] b,
   output logic signed [71:0]      p
);
   logic signed [71:0] p_ff;
   logic signed [71:0] p_in;

   assign p_in = en ? a * b : p_ff;

   always_ff @(posedge clock) begin
      p_ff <= p_in;
   end

   assign p = p_ff;
endmodule
`default_nettype wire

### rtl/dfso_cordic.sv
`default_nettype none
// Rotation-mode CORDIC, one micro-rotation per cycle, with a quarter-turn prestep.
module dfso_cordic #(
   parameter int STEPS = 16
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire logic signed [31:0] x_in,
   input  wire logic signed [31:0] y_in,
   input  wire logic signed [18:0] ang,
   output logic signed [35:0]      x_out,
   output logic signed [35:0]      y_out,
   output dfso_pkg::unit_stat_type stat
);
   localparam int CntW = $clog2(STEPS + 1);

   logic signed [35:0] x_ff, x_in_n, y_ff, y_in_n;
   logic signed [33:0] z_ff, z_in;
   logic [CntW-1:0]    i_ff, i_in;
   logic               busy_ff, busy_in, done_ff, done_in;
   logic signed [33:0] z0;
   logic signed [35:0] xs, ys;
   logic signed [33:0] at;

   assign z0 = 34'(ang) <<< 14;
   assign xs = x_ff >>> i_ff;
   assign ys = y_ff >>> i_ff;
   assign at = 34'(dfso_pkg::atan_q30(5'(i_ff)));

   always_comb begin
      x_in_n  = x_ff;
      y_in_n  = y_ff;
      z_in    = z_ff;
      i_in    = i_ff;
      busy_in = busy_ff;
      done_in = done_ff;
      if (start) begin
         busy_in = 1'b1;
         done_in = 1'b0;
         i_in    = '0;
         if (z0 > dfso_pkg::HALF_PI_Q30) begin
            x_in_n = -36'(y_in);
            y_in_n = 36'(x_in);
            z_in   = z0 - dfso_pkg::HALF_PI_Q30;
         end else if (z0 < -dfso_pkg::HALF_PI_Q30) begin
            x_in_n = 36'(y_in);
            y_in_n = -36'(x_in);
            z_in   = z0 + dfso_pkg::HALF_PI_Q30;
         end else begin
            x_in_n = 36'(x_in);
            y_in_n = 36'(y_in);
            z_in   = z0;
         end
      end else if (busy_ff) begin
         if (z_ff >= 0) begin
            x_in_n = x_ff - ys;
            y_in_n = y_ff + xs;
            z_in   = z_ff - at;
         end else begin
            x_in_n = x_ff + ys;
            y_in_n = y_ff - xs;
            z_in   = z_ff + at;
         end
         i_in = i_ff + 1'b1;
         if (i_ff == CntW'(STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      x_ff <= x_in_n;
      y_ff <= y_in_n;
      z_ff <= z_in;
      i_ff <= i_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign x_out = x_ff;
   assign y_out = y_ff;
   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
endmodule
`default_nettype wire

### rtl/dfso_wrap.sv
`default_nettype none
// Heading reduction into (-pi, pi]. The turn count is estimated on the shared
// multiplier from the upper magnitude bits times a reciprocal; the estimate is at
// most one turn short, so a single compare and subtract finishes the remainder.
module dfso_wrap (
   input  wire logic signed [42:0] sum,
   input  wire logic [20:0]        qd_lo,
   output logic [23:0]             mag_hi,
   output logic signed [18:0]      heading
);
   logic [39:0] mag;
   logic [20:0] r0, r1;
   logic signed [20:0] rem, fin, wr;

   always_comb begin
      mag = sum[42] ? 40'(-sum) : 40'(sum);
      r0  = mag[20:0] - qd_lo;
      r1  = (r0 >= 21'(dfso_pkg::TWO_PI_Q16)) ? r0 - 21'(dfso_pkg::TWO_PI_Q16) : r0;
      rem = signed'(r1);
      fin = (sum[42] && rem != 0) ? signed'({1'b0, dfso_pkg::TWO_PI_Q16}) - rem : rem;
      wr  = (fin > dfso_pkg::PI_Q16) ? fin - signed'({1'b0, dfso_pkg::TWO_PI_Q16}) : fin;
   end

   assign mag_hi  = mag[39:16];
   assign heading = wr[18:0];
endmodule
`default_nettype wire

### rtl/dual_flow_sensor_odometry_top.sv
`default_nettype none
// The block takes no request while one is in work, and a response that is not taken
// holds back the next pose update. The pace is set by the shared multiplier (eleven
// products, each formed in an S_MUL and then an S_CAP state) and by the CORDIC loop,
// one micro-rotation per cycle.
// Reset (synchronous, active high) clears the pose to zero and loads the default scales.
`include "dual_flow_sensor_odometry_top_macros.svh"
module dual_flow_sensor_odometry_top #(
   parameter int CORDIC_STEPS = 16
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic signed [15:0] req_right_dx,
   input  wire logic signed [15:0] req_right_dy,
   input  wire logic signed [15:0] req_left_dx,
   input  wire logic signed [15:0] req_left_dy,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic signed [31:0]      rsp_pos_x,
   output logic signed [31:0]      rsp_pos_y,
   output logic signed [18:0]      rsp_heading,
   input  wire logic               csr_valid,
   output logic                    csr_ready,
   input  wire logic [1:0]         csr_index,
   input  wire logic [23:0]        csr_wdata
);
   // Configuration registers. Writes are only expected while idle.
   logic [23:0]        mpc_ff, ib_ff;
   logic signed [23:0] fo_ff;

   // Sequencer state and the index of the product being formed.
   dfso_pkg::state_type st_ff, st_in;
   dfso_pkg::op_type    op_ff, op_in;

   // The request is held here for the whole computation.
   logic signed [15:0] rdxc_ff, rdyc_ff, ldxc_ff, ldyc_ff;

   // Intermediate results: per-sensor displacement in Q16.16, heading change,
   // the upper partial product of the offset correction, center motion and
   // rotated motion.
   logic signed [31:0] rdx_ff, rdy_ff, ldx_ff, ldy_ff;
   logic signed [31:0] rdx_in, rdy_in, ldx_in, ldy_in;
   logic signed [41:0] dth_ff, dth_in;
   logic signed [49:0] p1_ff, p1_in;
   logic signed [31:0] cx_ff, cy_ff, cx_in, cy_in;
   logic signed [37:0] gx_ff, gy_ff, gx_in, gy_in;

   // Heading reduction: the estimated number of whole turns and the low bits of
   // that count times two pi.
   logic [21:0] q_ff, q_in;
   logic [20:0] qd_ff, qd_in;

   // Pose accumulators double as the response payload, since they only
   // change when the response register is free.
   logic signed [31:0] accx_ff, accy_ff, accx_in, accy_in;
   logic signed [18:0] acch_ff, acch_in;
   logic               rspv_ff, rspv_in;

   // Sequencer controls.
   logic mul_en, unit_start, acc_en, out_free;

   logic signed [35:0] mul_a, mul_b;
   logic signed [71:0] mul_p;
   logic signed [71:0] rs8, rs16, rs30;
   logic signed [32:0] d33, sx, sy;
   logic signed [51:0] corr;
   logic signed [35:0] cord_x, cord_y;
   logic signed [18:0] wrap_h;
   logic signed [42:0] hsum;
   logic [23:0]        hmag_hi;
   dfso_pkg::unit_stat_type cord_stat;

   assign out_free = !rspv_ff || rsp_ready;

   // Next state.
   always_comb begin
      st_in = st_ff;
      op_in = op_ff;
      case (st_ff)
         dfso_pkg::S_IDLE: begin
            if (req_valid) begin
               st_in = dfso_pkg::S_MUL;
               op_in = dfso_pkg::OP_RDX;
            end
         end
         dfso_pkg::S_MUL: st_in = dfso_pkg::S_CAP;
         dfso_pkg::S_CAP: begin
            if (op_ff == dfso_pkg::OP_QD) begin
               st_in = dfso_pkg::S_ROT;
            end else if (op_ff == dfso_pkg::OP_GY) begin
               st_in = dfso_pkg::S_ACC;
            end else begin
               st_in = dfso_pkg::S_MUL;
               op_in = dfso_pkg::op_type'(op_ff + 4'd1);
            end
         end
         dfso_pkg::S_ROT: st_in = dfso_pkg::S_WAIT;
         dfso_pkg::S_WAIT: begin
            if (cord_stat.done) begin
               st_in = dfso_pkg::S_MUL;
               op_in = dfso_pkg::OP_GX;
            end
         end
         dfso_pkg::S_ACC: begin
            if (out_free) begin
               st_in = dfso_pkg::S_IDLE;
            end
         end
         default: st_in = dfso_pkg::S_IDLE;
      endcase
   end

   // Sequencer outputs.
   always_comb begin
      req_ready  = 1'b0;
      mul_en     = 1'b0;
      unit_start = 1'b0;
      acc_en     = 1'b0;
      case (st_ff)
         dfso_pkg::S_IDLE: req_ready  = 1'b1;
         dfso_pkg::S_MUL:  mul_en     = 1'b1;
         dfso_pkg::S_ROT:  unit_start = 1'b1;
         dfso_pkg::S_ACC:  acc_en     = out_free;
         default: ;
      endcase
   end

   // Operand selection for the shared multiplier.
   assign d33 = 33'(rdx_ff) - 33'(ldx_ff);
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (op_ff)
         dfso_pkg::OP_RDX: begin mul_a = 36'(rdxc_ff); mul_b = 36'(mpc_ff); end
         dfso_pkg::OP_RDY: begin mul_a = 36'(rdyc_ff); mul_b = 36'(mpc_ff); end
         dfso_pkg::OP_LDX: begin mul_a = 36'(ldxc_ff); mul_b = 36'(mpc_ff); end
         dfso_pkg::OP_LDY: begin mul_a = 36'(ldyc_ff); mul_b = 36'(mpc_ff); end
         dfso_pkg::OP_DTH: begin mul_a = 36'(d33); mul_b = 36'(ib_ff); end
         dfso_pkg::OP_FHI: begin mul_a = 36'(fo_ff); mul_b = 36'(dth_ff >>> 16); end
         dfso_pkg::OP_FLO: begin mul_a = 36'(fo_ff); mul_b = 36'(dth_ff[15:0]); end
         dfso_pkg::OP_QE:  begin mul_a = 36'(hmag_hi); mul_b = 36'(dfso_pkg::RECIP_Q42); end
         dfso_pkg::OP_QD:  begin mul_a = 36'(q_ff); mul_b = 36'(dfso_pkg::TWO_PI_Q16); end
         dfso_pkg::OP_GX:  begin mul_a = cord_x; mul_b = 36'(dfso_pkg::GAIN_Q30); end
         dfso_pkg::OP_GY:  begin mul_a = cord_y; mul_b = 36'(dfso_pkg::GAIN_Q30); end
         default: ;
      endcase
   end

   dfso_mul u_mul (
      .clock (clock),
      .en    (mul_en),
      .a     (mul_a),
      .b     (mul_b),
      .p     (mul_p)
   );

   // Rounding shifts of the product, half up.
   assign rs8  = (mul_p + 72'sd128) >>> 8;
   assign rs16 = (mul_p + 72'sd32768) >>> 16;
   assign rs30 = (mul_p + 72'sd536870912) >>> 30;

   // The offset correction is rebuilt exactly from its two partial products:
   // the upper part needs no rounding and the lower part carries it.
   assign corr = 52'(p1_ff) + 52'(signed'(rs16[25:0]));
   assign sx   = (33'(rdx_ff) + 33'(ldx_ff) + 33'sd1) >>> 1;
   assign sy   = (33'(rdy_ff) + 33'(ldy_ff) + 33'sd1) >>> 1;

   always_comb begin
      rdx_in = rdx_ff;
      rdy_in = rdy_ff;
      ldx_in = ldx_ff;
      ldy_in = ldy_ff;
      dth_in = dth_ff;
      p1_in  = p1_ff;
      cx_in  = cx_ff;
      cy_in  = cy_ff;
      q_in   = q_ff;
      qd_in  = qd_ff;
      gx_in  = gx_ff;
      gy_in  = gy_ff;
      if (st_ff == dfso_pkg::S_CAP) begin
         case (op_ff)
            dfso_pkg::OP_RDX: rdx_in = rs8[31:0];
            dfso_pkg::OP_RDY: rdy_in = rs8[31:0];
            dfso_pkg::OP_LDX: ldx_in = rs8[31:0];
            dfso_pkg::OP_LDY: ldy_in = rs8[31:0];
            dfso_pkg::OP_DTH: dth_in = rs16[41:0];
            dfso_pkg::OP_FHI: p1_in  = mul_p[49:0];
            dfso_pkg::OP_FLO: begin
               cx_in = dfso_pkg::sat32(52'(sx));
               cy_in = dfso_pkg::sat32(52'(sy) - corr);
            end
            dfso_pkg::OP_QE: q_in  = mul_p[47:26];
            dfso_pkg::OP_QD: qd_in = mul_p[20:0];
            dfso_pkg::OP_GX: gx_in = rs30[37:0];
            dfso_pkg::OP_GY: gy_in = rs30[37:0];
            default: ;
         endcase
      end
   end

   // The rotation uses the heading from before this request.
   assign hsum = 43'(acch_ff) + 43'(dth_ff);

   dfso_cordic #(
      .STEPS (CORDIC_STEPS)
   ) u_cordic (
      .clock (clock),
      .reset (reset),
      .start (unit_start),
      .x_in  (cx_ff),
      .y_in  (cy_ff),
      .ang   (acch_ff),
      .x_out (cord_x),
      .y_out (cord_y),
      .stat  (cord_stat)
   );

   dfso_wrap u_wrap (
      .sum     (hsum),
      .qd_lo   (qd_ff),
      .mag_hi  (hmag_hi),
      .heading (wrap_h)
   );

   // Pose update and response register.
   always_comb begin
      accx_in = accx_ff;
      accy_in = accy_ff;
      acch_in = acch_ff;
      rspv_in = rspv_ff && !rsp_ready;
      if (acc_en) begin
         accx_in = dfso_pkg::sat32(52'(accx_ff) + 52'(gx_ff));
         accy_in = dfso_pkg::sat32(52'(accy_ff) + 52'(gy_ff));
         acch_in = wrap_h;
         rspv_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         rdxc_ff <= req_right_dx;
         rdyc_ff <= req_right_dy;
         ldxc_ff <= req_left_dx;
         ldyc_ff <= req_left_dy;
      end
      rdx_ff <= rdx_in;
      rdy_ff <= rdy_in;
      ldx_ff <= ldx_in;
      ldy_ff <= ldy_in;
      dth_ff <= dth_in;
      p1_ff  <= p1_in;
      cx_ff  <= cx_in;
      cy_ff  <= cy_in;
      q_ff   <= q_in;
      qd_ff  <= qd_in;
      gx_ff  <= gx_in;
      gy_ff  <= gy_in;
      if (reset) begin
         st_ff   <= dfso_pkg::S_IDLE;
         op_ff   <= dfso_pkg::OP_RDX;
         accx_ff <= '0;
         accy_ff <= '0;
         acch_ff <= '0;
         rspv_ff <= 1'b0;
         mpc_ff  <= dfso_pkg::MPC_RESET;
         ib_ff   <= dfso_pkg::IB_RESET;
         fo_ff   <= dfso_pkg::FO_RESET;
      end else begin
         st_ff   <= st_in;
         op_ff   <= op_in;
         accx_ff <= accx_in;
         accy_ff <= accy_in;
         acch_ff <= acch_in;
         rspv_ff <= rspv_in;
         if (csr_valid && csr_ready) begin
            case (dfso_pkg::csr_idx_type'(csr_index))
               dfso_pkg::CSR_MPC: mpc_ff <= csr_wdata;
               dfso_pkg::CSR_IB:  ib_ff  <= csr_wdata;
               dfso_pkg::CSR_FO:  fo_ff  <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   assign csr_ready   = 1'b1;
   assign rsp_valid   = rspv_ff;
   assign rsp_pos_x   = accx_ff;
   assign rsp_pos_y   = accy_ff;
   assign rsp_heading = acch_ff;

   // Once a request is taken the block stays busy until its pose is posted.
   `DFSO_ASSERT(a_busy_after_req, clock, reset, (req_valid && req_ready) |=> !req_ready)
   // The CORDIC unit is never restarted while still iterating.
   `DFSO_ASSERT(a_start_idle, clock, reset, unit_start |-> !cord_stat.busy)
   // A pose update always shows up as a pending response in the next cycle.
   `DFSO_ASSERT(a_acc_posts, clock, reset, acc_en |=> rsp_valid)
   // The stored heading never leaves the wrapped range.
   `DFSO_ASSERT(a_head_range, clock, reset,
      (acch_ff <= 19'sd205887) && (acch_ff >= -19'sd205887))
endmodule
`default_nettype wire
